// ===== rtl/core/ptu_pkg.sv =====
// Shared types, constants and register codes of the packed tensor upsampler.
`timescale 1ns / 1ps
`default_nettype none
package ptu_pkg;

  // Default geometry limits (top-level parameter defaults)
  localparam int DEF_ATOM_BYTES   = 32;   // power of two, 8..64
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_MAX_BATCH    = 4;
  localparam int DEF_MAX_SCALE    = 8;

  // Field widths
  localparam int WORD_W     = 64;
  localparam int ADDR_W     = 34;
  localparam int WIDTH_W    = 9;
  localparam int HEIGHT_W   = 9;
  localparam int CHAN_W     = 11;
  localparam int BATCH_W    = 3;
  localparam int SCALE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Bytes per data word and its shift
  localparam int WORD_BYTES = 8;
  localparam int WORD_SHIFT = 3;

  // Width used for counter-against-limit compares
  localparam int CMP_W = 14;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd4;

  // Register reset values
  localparam logic [WIDTH_W-1:0]  RST_IN_WIDTH    = 9'd1;
  localparam logic [HEIGHT_W-1:0] RST_IN_HEIGHT   = 9'd1;
  localparam logic [CHAN_W-1:0]   RST_CHANNELS    = 11'd32;
  localparam logic [BATCH_W-1:0]  RST_BATCH_COUNT = 3'd1;
  localparam logic [SCALE_W-1:0]  RST_SCALE       = 4'd2;

  // Stride calculation sequence
  typedef enum logic [2:0] {
    CALC_LINE,
    CALC_ROW,
    CALC_SURF,
    CALC_CUBE,
    CALC_READY
  } ptu_calc_e;

  // Clamped geometry and byte strides of the output tensor
  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [CHAN_W-1:0]   surfaces;
    logic [BATCH_W-1:0]  batches;
    logic [ADDR_W-1:0]   atom_step;  // scale * atom
    logic [ADDR_W-1:0]   line;       // one output line
    logic [ADDR_W-1:0]   row_step;   // scale output lines
    logic [ADDR_W-1:0]   surf;       // one output surface
    logic [ADDR_W-1:0]   cube;       // one output tensor
  } ptu_strides_t;

  // One classified input word waiting for replication
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [WORD_W-1:0] word;
    logic              tensor_end;
  } ptu_job_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptu_ifs.sv =====
// Channel interfaces of the packed tensor upsampler: input, result and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface ptu_in_if;
  import ptu_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

interface ptu_out_if;
  import ptu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] dest_address;
  logic [WORD_W-1:0] write_word;
  logic              run_last;
  logic              tensor_last;
  modport source (output valid, output dest_address, output write_word,
                  output run_last, output tensor_last, input ready);
  modport sink   (input valid, input dest_address, input write_word,
                  input run_last, input tensor_last, output ready);
endinterface

interface ptu_cfg_if;
  import ptu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/packed_tensor_upsampler.sv =====
// Top level of the packed tensor nearest-neighbour upsampler.
//
//   Channel    Dir  Word                                       Accepted when
//   cfg_chan   in   index[2:0], data[10:0]                     valid && ready
//   in_chan    in   data_word[63:0]                            valid && ready
//   out_chan   out  dest_address, write_word, run_last,        valid && ready
//                   tensor_last
//
// Each input word gives scale*scale writes at one write per cycle while out_chan.ready
// is high; the replica walker in the back end produces them. A taken word passes the
// front end's offset and sum stages and the job queue before its first write is offered.
// After reset and after every register write, in_chan.ready is low while the stride
// calculation steps through line, row, surface and cube; cfg_chan.ready is always high.
// The front end keeps taking words while writes stall, until its queue fills.
`timescale 1ns / 1ps
`default_nettype none
module packed_tensor_upsampler #(
  parameter int ATOM_BYTES   = ptu_pkg::DEF_ATOM_BYTES,
  parameter int MAX_WIDTH    = ptu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = ptu_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = ptu_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_BATCH    = ptu_pkg::DEF_MAX_BATCH,
  parameter int MAX_SCALE    = ptu_pkg::DEF_MAX_SCALE
) (
  input  logic      clk,
  input  logic      rst_n,
  ptu_cfg_if.sink   cfg_chan,
  ptu_in_if.sink    in_chan,
  ptu_out_if.source out_chan
);
  import ptu_pkg::*;

  ptu_strides_t strides;
  logic         cfg_busy;
  logic         push_valid, queue_full, pop_valid, pop_ready;
  ptu_job_t     push_job, pop_job;

  ptu_cfg #(
    .ATOM_BYTES  (ATOM_BYTES),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_BATCH   (MAX_BATCH),
    .MAX_SCALE   (MAX_SCALE)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_chan),
    .strides (strides),
    .busy    (cfg_busy)
  );

  ptu_front #(
    .ATOM_BYTES  (ATOM_BYTES),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_CHANNELS(MAX_CHANNELS),
    .MAX_BATCH   (MAX_BATCH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .strides   (strides),
    .cfg_busy  (cfg_busy),
    .push_valid(push_valid),
    .push_job  (push_job),
    .queue_full(queue_full)
  );

  ptu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_job  (push_job),
    .full      (queue_full),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready)
  );

  ptu_back #(
    .ATOM_BYTES(ATOM_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_job  (pop_job),
    .pop_ready(pop_ready),
    .strides  (strides),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ===== rtl/core/ptu_cfg.sv =====
// Configuration registers, clamping and sequential stride calculation.
`timescale 1ns / 1ps
`default_nettype none
module ptu_cfg #(
  parameter int ATOM_BYTES   = ptu_pkg::DEF_ATOM_BYTES,
  parameter int MAX_WIDTH    = ptu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = ptu_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = ptu_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_BATCH    = ptu_pkg::DEF_MAX_BATCH,
  parameter int MAX_SCALE    = ptu_pkg::DEF_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ptu_cfg_if.sink               cfg_chan,
  output ptu_pkg::ptu_strides_t strides,
  output logic                  busy
);
  import ptu_pkg::*;

  localparam int LOG2_ATOM = $clog2(ATOM_BYTES);
  localparam int WPS_W     = WIDTH_W + SCALE_W;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [CHAN_W-1:0]   chan_r;
  logic [BATCH_W-1:0]  batch_r;
  logic [SCALE_W-1:0]  scale_r;

  logic [WIDTH_W-1:0]  width_c;
  logic [HEIGHT_W-1:0] height_c;
  logic [CHAN_W-1:0]   chan_c;
  logic [BATCH_W-1:0]  batch_c;
  logic [SCALE_W-1:0]  scale_c;
  logic [CHAN_W:0]     chan_round;
  logic [CHAN_W-1:0]   surfaces_c;
  logic [WPS_W-1:0]    width_x_scale;

  ptu_calc_e    state_r, state_nxt;
  ptu_strides_t strides_r;
  logic         cfg_fire;
  logic         ld_line, ld_row, ld_surf, ld_cube;

  assign cfg_chan.ready = 1'b1;
  assign cfg_fire       = cfg_chan.valid && cfg_chan.ready;

  // Hold the raw register values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IN_WIDTH;
      height_r <= RST_IN_HEIGHT;
      chan_r   <= RST_CHANNELS;
      batch_r  <= RST_BATCH_COUNT;
      scale_r  <= RST_SCALE;
    end else if (cfg_fire) begin
      unique case (cfg_chan.index)
        REG_IN_WIDTH:    width_r  <= cfg_chan.data[WIDTH_W-1:0];
        REG_IN_HEIGHT:   height_r <= cfg_chan.data[HEIGHT_W-1:0];
        REG_CHANNELS:    chan_r   <= cfg_chan.data[CHAN_W-1:0];
        REG_BATCH_COUNT: batch_r  <= cfg_chan.data[BATCH_W-1:0];
        REG_SCALE:       scale_r  <= cfg_chan.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp: zero reads as one, anything above the limit saturates
  always_comb begin
    width_c  = (width_r == '0) ? WIDTH_W'(1) :
               ((int'(width_r) > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : width_r);
    height_c = (height_r == '0) ? HEIGHT_W'(1) :
               ((int'(height_r) > MAX_HEIGHT) ? HEIGHT_W'(MAX_HEIGHT) : height_r);
    chan_c   = (chan_r == '0) ? CHAN_W'(1) :
               ((int'(chan_r) > MAX_CHANNELS) ? CHAN_W'(MAX_CHANNELS) : chan_r);
    batch_c  = (batch_r == '0) ? BATCH_W'(1) :
               ((int'(batch_r) > MAX_BATCH) ? BATCH_W'(MAX_BATCH) : batch_r);
    scale_c  = (scale_r == '0) ? SCALE_W'(1) :
               ((int'(scale_r) > MAX_SCALE) ? SCALE_W'(MAX_SCALE) : scale_r);
    chan_round    = {1'b0, chan_c} + (CHAN_W + 1)'(ATOM_BYTES - 1);
    surfaces_c    = CHAN_W'(chan_round >> LOG2_ATOM);
    width_x_scale = WPS_W'(width_c) * WPS_W'(scale_c);
  end

  // Next state: restart the calculation on every register write
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CALC_LINE:  state_nxt = CALC_ROW;
      CALC_ROW:   state_nxt = CALC_SURF;
      CALC_SURF:  state_nxt = CALC_CUBE;
      CALC_CUBE:  state_nxt = CALC_READY;
      CALC_READY: state_nxt = CALC_READY;
      default:    state_nxt = CALC_LINE;
    endcase
    if (cfg_fire) begin
      state_nxt = CALC_LINE;
    end
  end

  // Step strobes and busy flag
  always_comb begin
    ld_line = 1'b0;
    ld_row  = 1'b0;
    ld_surf = 1'b0;
    ld_cube = 1'b0;
    busy    = 1'b1;
    unique case (state_r)
      CALC_LINE:  ld_line = 1'b1;
      CALC_ROW:   ld_row  = 1'b1;
      CALC_SURF:  ld_surf = 1'b1;
      CALC_CUBE:  ld_cube = 1'b1;
      CALC_READY: busy    = 1'b0;
      default:    busy    = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CALC_LINE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // One multiplication per step
  always_ff @(posedge clk) begin
    if (ld_line) begin
      strides_r.scale     <= scale_c;
      strides_r.width     <= width_c;
      strides_r.height    <= height_c;
      strides_r.surfaces  <= surfaces_c;
      strides_r.batches   <= batch_c;
      strides_r.atom_step <= ADDR_W'(scale_c) << LOG2_ATOM;
      strides_r.line      <= ADDR_W'(width_x_scale) << LOG2_ATOM;
    end
    if (ld_row) begin
      strides_r.row_step <= strides_r.line * ADDR_W'(strides_r.scale);
    end
    if (ld_surf) begin
      strides_r.surf <= strides_r.row_step * ADDR_W'(strides_r.height);
    end
    if (ld_cube) begin
      strides_r.cube <= strides_r.surf * ADDR_W'(strides_r.surfaces);
    end
  end

  assign strides = strides_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptu_front.sv =====
// Front end: accepts input words, tracks tensor position, forms base addresses.
`timescale 1ns / 1ps
`default_nettype none
module ptu_front #(
  parameter int ATOM_BYTES   = ptu_pkg::DEF_ATOM_BYTES,
  parameter int MAX_WIDTH    = ptu_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = ptu_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = ptu_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_BATCH    = ptu_pkg::DEF_MAX_BATCH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ptu_in_if.sink                in_chan,
  input  ptu_pkg::ptu_strides_t strides,
  input  logic                  cfg_busy,
  output logic                  push_valid,
  output ptu_pkg::ptu_job_t     push_job,
  input  logic                  queue_full
);
  import ptu_pkg::*;

  localparam int WORDS_PER_ATOM = ATOM_BYTES / WORD_BYTES;
  localparam int MAX_SURF       = (MAX_CHANNELS + ATOM_BYTES - 1) / ATOM_BYTES;
  localparam int LANE_W  = (WORDS_PER_ATOM > 1) ? $clog2(WORDS_PER_ATOM) : 1;
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SURF_W  = (MAX_SURF > 1) ? $clog2(MAX_SURF) : 1;
  localparam int BIDX_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [SURF_W-1:0] surf_r, surf_nxt;
  logic [BIDX_W-1:0] bidx_r, bidx_nxt;
  logic lane_end, col_end, row_end, surf_end, bidx_end, all_end;

  logic accept, advance;

  logic              p1_valid_r;
  logic [WORD_W-1:0] p1_word_r;
  logic              p1_end_r;
  logic [ADDR_W-1:0] p1_off_batch_r, p1_off_surf_r, p1_off_row_r, p1_off_col_r;
  logic [ADDR_W-1:0] p1_off_lane_r;

  logic              p2_valid_r;
  logic [WORD_W-1:0] p2_word_r;
  logic              p2_end_r;
  logic [ADDR_W-1:0] p2_sum_hi_r, p2_sum_lo_r;

  // The pipeline moves unless its last stage is blocked by a full queue
  assign advance       = !p2_valid_r || !queue_full;
  assign in_chan.ready = advance && !cfg_busy;
  assign accept        = in_chan.valid && in_chan.ready;

  // Position end flags
  always_comb begin
    lane_end = (CMP_W'(lane_r) + CMP_W'(1)) >= CMP_W'(WORDS_PER_ATOM);
    col_end  = (CMP_W'(col_r)  + CMP_W'(1)) >= CMP_W'(strides.width);
    row_end  = (CMP_W'(row_r)  + CMP_W'(1)) >= CMP_W'(strides.height);
    surf_end = (CMP_W'(surf_r) + CMP_W'(1)) >= CMP_W'(strides.surfaces);
    bidx_end = (CMP_W'(bidx_r) + CMP_W'(1)) >= CMP_W'(strides.batches);
    all_end  = lane_end && col_end && row_end && surf_end && bidx_end;
  end

  // Advance the nested counters, innermost first
  always_comb begin
    lane_nxt = lane_end ? '0 : lane_r + LANE_W'(1);
    col_nxt  = col_r;
    row_nxt  = row_r;
    surf_nxt = surf_r;
    bidx_nxt = bidx_r;
    if (lane_end) begin
      col_nxt = col_end ? '0 : col_r + COL_W'(1);
      if (col_end) begin
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
        if (row_end) begin
          surf_nxt = surf_end ? '0 : surf_r + SURF_W'(1);
          if (surf_end) begin
            bidx_nxt = bidx_end ? '0 : bidx_r + BIDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= '0;
      col_r  <= '0;
      row_r  <= '0;
      surf_r <= '0;
      bidx_r <= '0;
    end else if (accept) begin
      lane_r <= lane_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      surf_r <= surf_nxt;
      bidx_r <= bidx_nxt;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else if (advance) begin
      p1_valid_r <= accept;
      p2_valid_r <= p1_valid_r;
    end
  end

  // Stage one: per-level offsets of the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_word_r      <= in_chan.data_word;
      p1_end_r       <= all_end;
      p1_off_batch_r <= ADDR_W'(bidx_r) * strides.cube;
      p1_off_surf_r  <= ADDR_W'(surf_r) * strides.surf;
      p1_off_row_r   <= ADDR_W'(row_r) * strides.row_step;
      p1_off_col_r   <= ADDR_W'(col_r) * strides.atom_step;
      p1_off_lane_r  <= ADDR_W'(lane_r) << WORD_SHIFT;
    end
  end

  // Stage two: partial sums
  always_ff @(posedge clk) begin
    if (advance) begin
      p2_word_r   <= p1_word_r;
      p2_end_r    <= p1_end_r;
      p2_sum_hi_r <= p1_off_batch_r + p1_off_surf_r;
      p2_sum_lo_r <= p1_off_row_r + p1_off_col_r + p1_off_lane_r;
    end
  end

  assign push_valid          = p2_valid_r && !queue_full;
  assign push_job.base       = p2_sum_hi_r + p2_sum_lo_r;
  assign push_job.word       = p2_word_r;
  assign push_job.tensor_end = p2_end_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptu_queue.sv =====
// Short job queue decoupling the front end from the replica writer.
`timescale 1ns / 1ps
`default_nettype none
module ptu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  ptu_pkg::ptu_job_t push_job,
  output logic              full,
  output logic              pop_valid,
  output ptu_pkg::ptu_job_t pop_job,
  input  logic              pop_ready
);
  import ptu_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ptu_job_t          slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Advance pointers, wrapping at the queue depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ptu_back.sv =====
// Back end: walks the scale x scale replica of each job and drives the write channel.
`timescale 1ns / 1ps
`default_nettype none
module ptu_back #(
  parameter int ATOM_BYTES = ptu_pkg::DEF_ATOM_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  ptu_pkg::ptu_job_t     pop_job,
  output logic                  pop_ready,
  input  ptu_pkg::ptu_strides_t strides,
  ptu_out_if.source             out_chan
);
  import ptu_pkg::*;

  logic               active_r;
  logic [ADDR_W-1:0]  addr_r, row_addr_r;
  logic [SCALE_W-1:0] x_r, y_r;
  logic [WORD_W-1:0]  word_r;
  logic               end_r;
  logic               x_last, y_last, last, fire, take;

  assign x_last    = (x_r + SCALE_W'(1)) == strides.scale;
  assign y_last    = (y_r + SCALE_W'(1)) == strides.scale;
  assign last      = x_last && y_last;
  assign fire      = active_r && out_chan.ready;
  assign pop_ready = !active_r || (fire && last);
  assign take      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (take) begin
      active_r <= 1'b1;
    end else if (fire && last) begin
      active_r <= 1'b0;
    end
  end

  // Load a new job, or step across the replica: columns one atom apart, then rows
  always_ff @(posedge clk) begin
    if (take) begin
      addr_r     <= pop_job.base;
      row_addr_r <= pop_job.base;
      x_r        <= '0;
      y_r        <= '0;
      word_r     <= pop_job.word;
      end_r      <= pop_job.tensor_end;
    end else if (fire && !last) begin
      if (x_last) begin
        x_r        <= '0;
        y_r        <= y_r + SCALE_W'(1);
        row_addr_r <= row_addr_r + strides.line;
        addr_r     <= row_addr_r + strides.line;
      end else begin
        x_r    <= x_r + SCALE_W'(1);
        addr_r <= addr_r + ADDR_W'(ATOM_BYTES);
      end
    end
  end

  assign out_chan.valid        = active_r;
  assign out_chan.dest_address = addr_r;
  assign out_chan.write_word   = word_r;
  assign out_chan.run_last     = last;
  assign out_chan.tensor_last  = last && end_r;

endmodule
`default_nettype wire

// ===== rtl/core/ptu_port_checker.sv =====
// Port-level checks of the upsampler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ptu_port_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ptu_pkg::WORD_W-1:0] write_word,
  input logic                       run_last,
  input logic                       tensor_last
);
  import ptu_pkg::*;

  // A stalled write stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("write dropped while stalled");

  // The end of the tensor is always the end of a run
  a_tensor_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && tensor_last |-> run_last)
    else $error("tensor_last without run_last");

  // Within a run the next write follows at once with the same word
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !run_last |=> out_valid && $stable(write_word))
    else $error("replica run broken");

  // A register write blocks input while strides are recalculated
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during stride calculation");

endmodule

bind packed_tensor_upsampler ptu_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_chan.valid),
  .cfg_ready  (cfg_chan.ready),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .write_word (out_chan.write_word),
  .run_last   (out_chan.run_last),
  .tensor_last(out_chan.tensor_last)
);
`default_nettype wire

// ===== bench/ptu_write_checker.sv =====
// Predicts the replica writes of the packed tensor upsampler and checks each one.
`timescale 1ns / 1ps
module ptu_write_checker
  import ptu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ptu_cfg_if   cfg_mon,
  ptu_in_if    in_mon,
  ptu_out_if   out_mon,
  output int   error_count,
  output int   writes_pending
);

  localparam int ATOM       = DEF_ATOM_BYTES;
  localparam int LANES      = ATOM / WORD_BYTES;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              run_last;
    logic              tensor_last;
  } replica_write_t;

  // Register copies as last written
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [CHAN_W-1:0]   chan_reg;
  logic [BATCH_W-1:0]  batch_reg;
  logic [SCALE_W-1:0]  scale_reg;

  // Position of the next input word in the source tensor
  logic [1:0] lane_pos;
  logic [7:0] col_pos;
  logic [7:0] row_pos;
  logic [4:0] surf_pos;
  logic [1:0] batch_pos;

  replica_write_t expected_writes[$];
  int errs = 0;

  // Zero reads as one, anything above the limit saturates
  function automatic bit [63:0] clamp_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 64'd1;
    if (v > hi) return 64'(hi);
    return 64'(v);
  endfunction

  // Queue the scale x scale writes of one word and step the position
  task automatic replicate_word(input logic [WORD_W-1:0] data);
    bit [63:0] wd, ht, ch, bc, s, surfaces, line, surf, cube, base;
    bit lane_end, col_end, row_end, surf_end, batch_end;
    replica_write_t rw;
    wd = clamp_reg(width_reg, DEF_MAX_WIDTH);
    ht = clamp_reg(height_reg, DEF_MAX_HEIGHT);
    ch = clamp_reg(chan_reg, DEF_MAX_CHANNELS);
    bc = clamp_reg(batch_reg, DEF_MAX_BATCH);
    s  = clamp_reg(scale_reg, DEF_MAX_SCALE);
    surfaces = (ch + ATOM - 1) / ATOM;
    line = wd * ATOM * s;
    surf = wd * ht * ATOM * s * s;
    cube = surf * surfaces;
    base = batch_pos * cube + surf_pos * surf + row_pos * s * line
         + col_pos * s * ATOM + lane_pos * WORD_BYTES;

    lane_end  = (lane_pos + 1 >= LANES);
    col_end   = (col_pos + 1 >= wd);
    row_end   = (row_pos + 1 >= ht);
    surf_end  = (surf_pos + 1 >= surfaces);
    batch_end = (batch_pos + 1 >= bc);

    for (int y = 0; y < s; y++) begin
      for (int x = 0; x < s; x++) begin
        rw.addr        = ADDR_W'(base + y * line + x * ATOM);  // wraps at the address width
        rw.word        = data;
        rw.run_last    = (y == s - 1) && (x == s - 1);
        rw.tensor_last = rw.run_last && lane_end && col_end && row_end && surf_end
                         && batch_end;
        expected_writes.push_back(rw);
      end
    end

    // Advance lane, column, row, surface, batch; each wraps at its limit
    lane_pos = lane_end ? '0 : lane_pos + 1'b1;
    if (lane_end) col_pos = col_end ? '0 : col_pos + 1'b1;
    if (lane_end && col_end) row_pos = row_end ? '0 : row_pos + 1'b1;
    if (lane_end && col_end && row_end) surf_pos = surf_end ? '0 : surf_pos + 1'b1;
    if (lane_end && col_end && row_end && surf_end)
      batch_pos = batch_end ? '0 : batch_pos + 1'b1;
  endtask

  task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    replica_write_t want;
    if (!rst_n) begin
      width_reg  = RST_IN_WIDTH;
      height_reg = RST_IN_HEIGHT;
      chan_reg   = RST_CHANNELS;
      batch_reg  = RST_BATCH_COUNT;
      scale_reg  = RST_SCALE;
      lane_pos   = '0;
      col_pos    = '0;
      row_pos    = '0;
      surf_pos   = '0;
      batch_pos  = '0;
      expected_writes.delete();
    end else begin
      // Take register writes; the position counters are kept
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_IN_WIDTH:    width_reg  = cfg_mon.data[WIDTH_W-1:0];
          REG_IN_HEIGHT:   height_reg = cfg_mon.data[HEIGHT_W-1:0];
          REG_CHANNELS:    chan_reg   = cfg_mon.data[CHAN_W-1:0];
          REG_BATCH_COUNT: batch_reg  = cfg_mon.data[BATCH_W-1:0];
          REG_SCALE:       scale_reg  = cfg_mon.data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) replicate_word(in_mon.data_word);
      // Compare each write with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_writes.size() == 0) begin
          errs++;
          $display("%0t: unexpected write: expected none, got addr %h word %h run %b end %b",
                   $time, out_mon.dest_address, out_mon.write_word, out_mon.run_last,
                   out_mon.tensor_last);
        end else begin
          want = expected_writes.pop_front();
          check_field("dest_address", want.addr, out_mon.dest_address);
          check_field("write_word", want.word, out_mon.write_word);
          check_field("run_last", want.run_last, out_mon.run_last);
          check_field("tensor_last", want.tensor_last, out_mon.tensor_last);
        end
      end
    end
    error_count    <= errs;
    writes_pending <= expected_writes.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus, clock, reset and verdict for the packed tensor upsampler bench.
`timescale 1ns / 1ps
module tb_top;
  import ptu_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_WORDS = 320;
  localparam int DATA_MAX     = (1 << CFG_DATA_W) - 1;
  localparam logic [CFG_IDX_W-1:0] LAST_INDEX = '1;

  logic clk;
  logic rst_n;
  bit   calm = 1'b0;
  int   sink_hold = 0;
  int   cycle_count = 0;
  int   check_errors;
  int   check_pending;

  ptu_cfg_if cfg_chan ();
  ptu_in_if  in_chan ();
  ptu_out_if out_chan ();

  packed_tensor_upsampler DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ptu_write_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_mon        (cfg_chan),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .error_count    (check_errors),
    .writes_pending (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 75) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Stall the write side at random
  always @(posedge clk) begin : write_stall
    int stall;
    stall = pick_gap();
    if (sink_hold > 0) begin
      out_chan.ready <= 1'b0;
      sink_hold      <= sink_hold - 1;
    end else if (stall == 0) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= 1'b0;
      sink_hold      <= stall - 1;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold a word until taken; valid stays high when the next word follows at once
  task automatic send_word(input logic [WORD_W-1:0] word);
    int gap;
    in_chan.valid     <= 1'b1;
    in_chan.data_word <= word;
    do @(posedge clk); while (!in_chan.ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
  endtask

  // Drop valid and wait until every predicted write has come out
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
  endtask

  // Pick a geometry, mostly small, and write a random subset of the registers
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  ids  [5];
    int roll;
    ids = '{REG_IN_WIDTH, REG_IN_HEIGHT, REG_CHANNELS, REG_BATCH_COUNT, REG_SCALE};
    roll = $urandom_range(0, 9);
    vals[0] = CFG_DATA_W'((roll < 7) ? $urandom_range(1, 4) :
              (roll < 9) ? $urandom_range(5, 16) : $urandom_range(0, DATA_MAX));
    roll = $urandom_range(0, 9);
    vals[1] = CFG_DATA_W'((roll < 7) ? $urandom_range(1, 3) :
              (roll < 9) ? $urandom_range(4, 8) : $urandom_range(0, DATA_MAX));
    roll = $urandom_range(0, 9);
    vals[2] = CFG_DATA_W'((roll < 6) ? $urandom_range(1, 64) :
              (roll < 9) ? $urandom_range(65, 160) : $urandom_range(0, DATA_MAX));
    vals[3] = CFG_DATA_W'($urandom_range(0, 7));
    roll = $urandom_range(0, 9);
    vals[4] = CFG_DATA_W'((roll < 5) ? $urandom_range(1, 2) :
              (roll < 8) ? $urandom_range(3, 4) :
              (roll < 9) ? $urandom_range(5, 8) : $urandom_range(0, 15));
    for (int r = 0; r < 5; r++)
      if ($urandom_range(0, 4) != 0) write_reg(ids[r], vals[r]);
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_SCALE + 1, LAST_INDEX)),
                CFG_DATA_W'($urandom));
    cfg_chan.valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [WORD_W-1:0] corner_words [5];
    int sent;
    int n_items;
    corner_words = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h8080_8080_8080_8080, 64'h7F7F_7F7F_7F7F_7F7F,
                     64'h0123_4567_89AB_CDEF};
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.data_word <= '0;
    cfg_chan.valid    <= 1'b0;
    cfg_chan.index    <= '0;
    cfg_chan.data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: one atom per tensor, so the fourth word ends the batch
    foreach (corner_words[i]) send_word(corner_words[i]);

    // Zero and oversized values, unknown index; 32 surfaces of one pixel
    drain();
    write_reg(REG_IN_WIDTH, '0);
    write_reg(REG_IN_HEIGHT, '0);
    write_reg(REG_CHANNELS, DATA_MAX);
    write_reg(REG_BATCH_COUNT, '0);
    write_reg(REG_SCALE, '0);
    write_reg(LAST_INDEX, DATA_MAX);
    cfg_chan.valid <= 1'b0;
    repeat (16) send_word({$urandom, $urandom});

    // Grow the geometry mid-stream to oversized values, then write an unknown index
    drain();
    write_reg(REG_IN_WIDTH, 11'd511);
    write_reg(REG_IN_HEIGHT, 11'd300);
    write_reg(REG_BATCH_COUNT, 11'd7);
    write_reg(REG_SCALE, 11'd15);
    write_reg(CFG_IDX_W'(REG_SCALE + 1), '0);
    cfg_chan.valid <= 1'b0;
    repeat (2) send_word({$urandom, $urandom});

    // Random phases, each on a fresh setting
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      drain();
      random_setup();
      calm    <= ($urandom_range(0, 3) == 0);
      n_items  = $urandom_range(10, 40);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 39) == 0) drain();
        send_word({$urandom, $urandom});
      end
      sent += n_items;
    end

    // Let the last writes out, then give the verdict
    drain();
    repeat (8) @(posedge clk);
    if (check_errors == 0 && check_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
